### src/tsfp_pkg.sv
// Shared types and character constants for the telemetry sentence field parser.
// No dependencies.
package tsfp_pkg;

    typedef enum logic [2:0] {
        KEY_NONE,
        KEY_RLL,
        KEY_PCH,
        KEY_YAW,
        KEY_LAT,
        KEY_LON,
        KEY_SAT
    } key_t;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_Y     = 8'h59;

    localparam int ACC_W = 33;
    localparam logic [ACC_W-1:0] ACC_CAP = 33'h1_0000_0000;

    localparam logic [1:0] FRAC_CLOSED = 2'd3;

    localparam logic [1:0] POS_START = 2'd0;
    localparam logic [1:0] POS_FIRST = 2'd1;
    localparam logic [1:0] POS_BODY  = 2'd2;

endpackage

### src/telemetry_sentence_field_parser_unit.sv
// Bytes are registered on entry; a result is registered as its newline advances.
// Throughput: one byte per cycle; the input register stalls only while a result
// waits at the output and the byte in the input register ends an accepted line.
// Reset (rst_n, async, active low) clears the line parser, the held values
// and both valid flags. Depends on tsfp_pkg.
module telemetry_sentence_field_parser_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         ch,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [17:0] roll,
    output logic signed [17:0] pitch,
    output logic signed [17:0] yaw,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude,
    output logic [7:0]         satellites
);
    import tsfp_pkg::*;

    function automatic logic [ACC_W-1:0] cap_acc(input logic [39:0] v);
        if (v > {7'd0, ACC_CAP})
        begin
            return ACC_CAP;
        end
        return v[ACC_W-1:0];
    endfunction

    logic              s1_valid_reg;
    logic [7:0]        ch_reg;
    logic [1:0]        line_pos_reg, line_pos_next;
    logic              skip_reg, skip_next;
    logic [7:0]        key0_reg, key0_next;
    logic [7:0]        key1_reg, key1_next;
    logic [7:0]        key2_reg, key2_next;
    logic [2:0]        key_len_reg, key_len_next;
    logic              in_value_reg, in_value_next;
    logic              neg_reg, neg_next;
    logic              seen_point_reg, seen_point_next;
    logic [1:0]        frac_reg, frac_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [17:0] roll_h_reg, roll_h_next;
    logic signed [17:0] pitch_h_reg, pitch_h_next;
    logic signed [17:0] yaw_h_reg, yaw_h_next;
    logic signed [31:0] lat_h_reg, lat_h_next;
    logic signed [31:0] lon_h_reg, lon_h_next;
    logic [7:0]        sat_h_reg, sat_h_next;
    logic              out_valid_reg;
    logic signed [17:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [31:0] lat_reg, lon_reg;
    logic [7:0]        sat_reg;

    key_t              key;
    logic              angle;
    logic              emit;
    logic              do_commit;
    logic              advance;
    logic [3:0]        digit;
    logic [39:0]       acc_x10;
    logic [39:0]       acc_x100;
    logic [16:0]       angle_mag;
    logic signed [17:0] angle_val;
    logic signed [31:0] pos_val;
    logic [7:0]        sat_val;

    // key decode
    always_comb
    begin
        key = KEY_NONE;
        if (key_len_reg == 3'd3)
        begin
            if (key0_reg == CH_R && key1_reg == CH_L && key2_reg == CH_L)
                key = KEY_RLL;
            else if (key0_reg == CH_P && key1_reg == CH_C && key2_reg == CH_H)
                key = KEY_PCH;
            else if (key0_reg == CH_Y && key1_reg == CH_A && key2_reg == CH_W)
                key = KEY_YAW;
            else if (key0_reg == CH_L && key1_reg == CH_A && key2_reg == CH_T)
                key = KEY_LAT;
            else if (key0_reg == CH_L && key1_reg == CH_O && key2_reg == CH_N)
                key = KEY_LON;
            else if (key0_reg == CH_S && key1_reg == CH_A && key2_reg == CH_T)
                key = KEY_SAT;
        end
        angle = (key == KEY_RLL) || (key == KEY_PCH) || (key == KEY_YAW);
    end

    // values to store when a field closes
    always_comb
    begin
        if (seen_point_reg)
            angle_mag = (acc_reg > 33'd99999) ? 17'd99999 : acc_reg[16:0];
        else
            angle_mag = (acc_reg > 33'd999) ? 17'd99999
                                            : {7'd0, acc_reg[9:0]} * 17'd100;
        angle_val = neg_reg ? -$signed({1'b0, angle_mag}) : $signed({1'b0, angle_mag});

        if (neg_reg)
            pos_val = (acc_reg >= 33'h0_8000_0000) ? 32'sh8000_0000
                                                  : -$signed(acc_reg[31:0]);
        else
            pos_val = (acc_reg > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                 : $signed(acc_reg[31:0]);

        if (neg_reg)
            sat_val = 8'd0;
        else
            sat_val = (acc_reg > 33'd255) ? 8'd255 : acc_reg[7:0];
    end

    assign digit    = 4'(ch_reg - CH_ZERO);
    assign acc_x10  = {4'd0, acc_reg, 3'd0} + {6'd0, acc_reg, 1'b0} + {36'd0, digit};
    assign acc_x100 = {1'b0, acc_reg, 6'd0} + {2'd0, acc_reg, 5'd0} + {5'd0, acc_reg, 2'd0};

    // parser next state
    always_comb
    begin
        line_pos_next   = line_pos_reg;
        skip_next       = skip_reg;
        key0_next       = key0_reg;
        key1_next       = key1_reg;
        key2_next       = key2_reg;
        key_len_next    = key_len_reg;
        in_value_next   = in_value_reg;
        neg_next        = neg_reg;
        seen_point_next = seen_point_reg;
        frac_next       = frac_reg;
        acc_next        = acc_reg;
        emit            = 1'b0;
        do_commit       = 1'b0;

        if (ch_reg == CH_NL)
        begin
            if (line_pos_reg == POS_BODY && !skip_reg)
            begin
                do_commit = 1'b1;
                emit      = 1'b1;
            end
            line_pos_next = POS_START;
            skip_next     = 1'b0;
        end
        else if (!skip_reg)
        begin
            if (line_pos_reg == POS_FIRST && ch_reg != CH_BANG)
            begin
                skip_next     = 1'b1;
                line_pos_next = POS_BODY;
            end
            else
            begin
                if (line_pos_reg != POS_BODY)
                    line_pos_next = line_pos_reg + 2'd1;
                if (ch_reg == CH_COMMA)
                begin
                    do_commit = 1'b1;
                end
                else if (!in_value_reg)
                begin
                    if (ch_reg == CH_COLON)
                    begin
                        in_value_next   = 1'b1;
                        neg_next        = 1'b0;
                        seen_point_next = 1'b0;
                        frac_next       = 2'd0;
                        acc_next        = '0;
                    end
                    else
                    begin
                        case (key_len_reg)
                            3'd0:    key0_next = ch_reg;
                            3'd1:    key1_next = ch_reg;
                            3'd2:    key2_next = ch_reg;
                            default: ;
                        endcase
                        if (key_len_reg < 3'd4)
                            key_len_next = key_len_reg + 3'd1;
                    end
                end
                else if (frac_reg != FRAC_CLOSED)
                begin
                    if (ch_reg inside {[CH_ZERO:CH_NINE]})
                    begin
                        if (!seen_point_reg)
                        begin
                            acc_next = cap_acc(acc_x10);
                        end
                        else if (frac_reg == 2'd0)
                        begin
                            acc_next  = cap_acc({7'd0, acc_reg} + ({36'd0, digit} * 40'd10));
                            frac_next = 2'd1;
                        end
                        else if (frac_reg == 2'd1)
                        begin
                            acc_next  = cap_acc({7'd0, acc_reg} + {36'd0, digit});
                            frac_next = 2'd2;
                        end
                    end
                    else if (ch_reg == CH_MINUS && !neg_reg && acc_reg == '0
                             && !seen_point_reg)
                    begin
                        neg_next = 1'b1;
                    end
                    else if (ch_reg == CH_POINT && angle && !seen_point_reg)
                    begin
                        acc_next        = cap_acc(acc_x100);
                        seen_point_next = 1'b1;
                        frac_next       = 2'd0;
                    end
                    else
                    begin
                        if (!seen_point_reg)
                        begin
                            if (angle)
                                acc_next = cap_acc(acc_x100);
                            seen_point_next = 1'b1;
                        end
                        frac_next = FRAC_CLOSED;
                    end
                end
            end
        end

        // a closed field clears the field state
        if (do_commit)
        begin
            key0_next       = '0;
            key1_next       = '0;
            key2_next       = '0;
            key_len_next    = '0;
            in_value_next   = 1'b0;
            neg_next        = 1'b0;
            seen_point_next = 1'b0;
            frac_next       = 2'd0;
            acc_next        = '0;
        end
        if (ch_reg == CH_NL)
        begin
            key0_next       = '0;
            key1_next       = '0;
            key2_next       = '0;
            key_len_next    = '0;
            in_value_next   = 1'b0;
            neg_next        = 1'b0;
            seen_point_next = 1'b0;
            frac_next       = 2'd0;
            acc_next        = '0;
        end
    end

    // held values
    always_comb
    begin
        roll_h_next  = roll_h_reg;
        pitch_h_next = pitch_h_reg;
        yaw_h_next   = yaw_h_reg;
        lat_h_next   = lat_h_reg;
        lon_h_next   = lon_h_reg;
        sat_h_next   = sat_h_reg;
        if (do_commit && in_value_reg)
        begin
            case (key)
                KEY_RLL: roll_h_next  = angle_val;
                KEY_PCH: pitch_h_next = angle_val;
                KEY_YAW: yaw_h_next   = angle_val;
                KEY_LAT: lat_h_next   = pos_val;
                KEY_LON: lon_h_next   = pos_val;
                KEY_SAT: sat_h_next   = sat_val;
                default: ;
            endcase
        end
    end

    assign advance  = s1_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            line_pos_reg   <= POS_START;
            skip_reg       <= 1'b0;
            key0_reg       <= '0;
            key1_reg       <= '0;
            key2_reg       <= '0;
            key_len_reg    <= '0;
            in_value_reg   <= 1'b0;
            neg_reg        <= 1'b0;
            seen_point_reg <= 1'b0;
            frac_reg       <= 2'd0;
            acc_reg        <= '0;
            roll_h_reg     <= '0;
            pitch_h_reg    <= '0;
            yaw_h_reg      <= '0;
            lat_h_reg      <= '0;
            lon_h_reg      <= '0;
            sat_h_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                line_pos_reg   <= line_pos_next;
                skip_reg       <= skip_next;
                key0_reg       <= key0_next;
                key1_reg       <= key1_next;
                key2_reg       <= key2_next;
                key_len_reg    <= key_len_next;
                in_value_reg   <= in_value_next;
                neg_reg        <= neg_next;
                seen_point_reg <= seen_point_next;
                frac_reg       <= frac_next;
                acc_reg        <= acc_next;
                roll_h_reg     <= roll_h_next;
                pitch_h_reg    <= pitch_h_next;
                yaw_h_reg      <= yaw_h_next;
                lat_h_reg      <= lat_h_next;
                lon_h_reg      <= lon_h_next;
                sat_h_reg      <= sat_h_next;
            end
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ch_reg <= ch;
        if (advance && emit)
        begin
            roll_reg  <= roll_h_next;
            pitch_reg <= pitch_h_next;
            yaw_reg   <= yaw_h_next;
            lat_reg   <= lat_h_next;
            lon_reg   <= lon_h_next;
            sat_reg   <= sat_h_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign roll       = roll_reg;
    assign pitch      = pitch_reg;
    assign yaw        = yaw_reg;
    assign latitude   = lat_reg;
    assign longitude  = lon_reg;
    assign satellites = sat_reg;

endmodule

### src/tsfp_checker.sv
// Port-level checks for telemetry_sentence_field_parser_unit, bound to the top level.
// Depends on tsfp_pkg and the top level's port names.
module tsfp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [7:0]         ch,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [17:0] roll,
    input logic signed [17:0] pitch,
    input logic signed [17:0] yaw,
    input logic signed [31:0] latitude,
    input logic signed [31:0] longitude,
    input logic [7:0]         satellites
);
    import tsfp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll) && $stable(pitch)
            && $stable(yaw) && $stable(latitude) && $stable(longitude)
            && $stable(satellites))
        else $error("result changed while stalled");

    // a new result follows a newline transaction
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && ch == CH_NL, 2))
        else $error("result without a newline transaction");

    // angles stay within the saturated range
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll >= -18'sd99999) && (roll <= 18'sd99999)
            && (pitch >= -18'sd99999) && (pitch <= 18'sd99999)
            && (yaw >= -18'sd99999) && (yaw <= 18'sd99999))
        else $error("angle out of range");

endmodule

bind telemetry_sentence_field_parser_unit tsfp_checker u_tsfp_checker (.*);
